// File: design/sccr_pkg.sv
package sccr_pkg;

    // request kinds carried in the low bits of s_axis_tuser
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // register indexes
    localparam int REG_ACTIVE_SLOTS = 0;

    // flag store update codes
    localparam logic [2:0] FC_NONE      = 3'd0;
    localparam logic [2:0] FC_HIT       = 3'd1;
    localparam logic [2:0] FC_CLR_ACC   = 3'd2;
    localparam logic [2:0] FC_CLR_META  = 3'd3;
    localparam logic [2:0] FC_LOAD      = 3'd4;
    localparam logic [2:0] FC_CLR_DIRTY = 3'd5;

    typedef struct packed {
        logic [2:0] code;
        logic       wr;    // request was a write
        logic       meta;  // requested sector holds metadata
    } t_flag_cmd;

    typedef struct packed {
        logic valid;
        logic dirty;
        logic accessed;
        logic meta_chance;
        logic holds_meta;
    } t_slot_flags;

endpackage

// File: design/sccr_ram.sv
module sccr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sccr_flags.sv
module sccr_flags
    import sccr_pkg::*;
#(
    parameter int CACHE_SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_flag_cmd                      i_cmd,
    input  logic [$clog2(CACHE_SLOTS)-1:0] i_cmd_idx,
    input  logic [$clog2(CACHE_SLOTS)-1:0] i_rd_idx,
    output t_slot_flags                    o_rd
);

    logic [CACHE_SLOTS-1:0] r_valid;
    logic [CACHE_SLOTS-1:0] r_dirty;
    logic [CACHE_SLOTS-1:0] r_acc;
    logic [CACHE_SLOTS-1:0] r_mchance;
    logic [CACHE_SLOTS-1:0] r_hmeta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_acc     <= '0;
            r_mchance <= '0;
            r_hmeta   <= '0;
        end else begin
            case (i_cmd.code)
                FC_HIT: begin
                    r_acc[i_cmd_idx] <= 1'b1;
                    if (i_cmd.wr) begin
                        r_dirty[i_cmd_idx] <= 1'b1;
                    end
                    if (r_hmeta[i_cmd_idx]) begin
                        r_mchance[i_cmd_idx] <= 1'b1;
                    end
                end
                FC_CLR_ACC: begin
                    r_acc[i_cmd_idx] <= 1'b0;
                end
                FC_CLR_META: begin
                    r_mchance[i_cmd_idx] <= 1'b0;
                end
                FC_LOAD: begin
                    r_valid[i_cmd_idx]   <= 1'b1;
                    r_acc[i_cmd_idx]     <= 1'b1;
                    r_dirty[i_cmd_idx]   <= i_cmd.wr;
                    r_hmeta[i_cmd_idx]   <= i_cmd.meta;
                    r_mchance[i_cmd_idx] <= i_cmd.meta;
                end
                FC_CLR_DIRTY: begin
                    r_dirty[i_cmd_idx] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_rd.valid       = r_valid[i_rd_idx];
        o_rd.dirty       = r_dirty[i_rd_idx];
        o_rd.accessed    = r_acc[i_rd_idx];
        o_rd.meta_chance = r_mchance[i_rd_idx];
        o_rd.holds_meta  = r_hmeta[i_rd_idx];
    end

endmodule

// File: design/sector_cache_clock_replacement.sv
// Tag and clock (second chance) replacement engine for a sector cache. One request is
// taken at a time; s_axis_tready is high only while the engine is idle. A read or write
// walks the tag RAM one slot per cycle. A miss searches the n active slots, steps the
// clock hand (at most n steps), then reads the victim tag, makes the update and returns
// to idle. A flush reads each active slot in turn and gives one result item per slot,
// the last marked by m_axis_tlast; each item waits while the output is held. All tag
// reads share the single tag RAM read port. Results sit in an output register, so the
// next request may be taken while one still waits.
// active_slots (byte address 0) is to be written only while the engine is idle.
module sector_cache_clock_replacement
    import sccr_pkg::*;
#(
    parameter int CACHE_SLOTS = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sector
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [((SECTOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op [1:0], is_metadata [2]
    input  logic [2:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit, slot, writeback, writeback_sector, load_needed, zero pad
    output logic [((SECTOR_BITS+$clog2(CACHE_SLOTS)+3+7)/8)*8-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int SLOT_W   = $clog2(CACHE_SLOTS);
    localparam int CFG_W    = $clog2(CACHE_SLOTS + 1);
    localparam int IW       = SLOT_W + 1;
    localparam int OUT_BITS = SECTOR_BITS + SLOT_W + 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_VRD  = 3'd4;
    localparam logic [2:0] S_VOUT = 3'd5;
    localparam logic [2:0] S_FRD  = 3'd6;
    localparam logic [2:0] S_FOUT = 3'd7;

    logic [2:0]             r_state, n_state;
    logic [CFG_W-1:0]       r_active;
    logic [1:0]             r_op;
    logic [SECTOR_BITS-1:0] r_sector;
    logic                   r_meta;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0]      r_hand, n_hand;
    logic [SLOT_W-1:0]      r_start, n_start;
    logic [SLOT_W-1:0]      r_vic, n_vic;
    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out_data;
    logic                   r_out_last;

    logic                   accept;
    logic                   cfg_wr;
    logic [IW-1:0]          n_cnt;
    logic [IW-1:0]          last_idx;
    logic [IW-1:0]          hand_nx;
    logic [SLOT_W-1:0]      hand_adv;
    logic                   out_free;
    logic                   issue;

    logic                   ram_we;
    logic                   ram_re;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [SECTOR_BITS-1:0] ram_rdata;

    t_flag_cmd              fcmd;
    logic [SLOT_W-1:0]      fcmd_idx;
    logic [SLOT_W-1:0]      frd_idx;
    t_slot_flags            fl;

    logic                   load_out;
    logic                   o_hit;
    logic [SLOT_W-1:0]      o_slot;
    logic                   o_wb;
    logic [SECTOR_BITS-1:0] o_wbs;
    logic                   o_load;
    logic                   o_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_ACTIVE_SLOTS));
    assign prdata = (paddr[2] == 1'(REG_ACTIVE_SLOTS)) ? 32'(r_active) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_W'(CACHE_SLOTS);
        end else if (cfg_wr) begin
            r_active <= pwdata[CFG_W-1:0];
        end
    end

    // zero acts as one, oversize as the full cache
    always_comb begin
        if (r_active == '0) begin
            n_cnt = IW'(1);
        end else if (r_active > CFG_W'(CACHE_SLOTS)) begin
            n_cnt = IW'(CACHE_SLOTS);
        end else begin
            n_cnt = IW'(r_active);
        end
    end

    assign last_idx = n_cnt - IW'(1);
    assign hand_nx  = {1'b0, r_hand} + IW'(1);
    assign hand_adv = (hand_nx >= n_cnt) ? '0 : hand_nx[SLOT_W-1:0];
    assign issue    = (r_idx < n_cnt);
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    sccr_ram #(
        .WIDTH (SECTOR_BITS),
        .DEPTH (CACHE_SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_vic),
        .i_wdata (r_sector),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sccr_flags #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_flags (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (fcmd),
        .i_cmd_idx (fcmd_idx),
        .i_rd_idx  (frd_idx),
        .o_rd      (fl)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_hand    = r_hand;
        n_start   = r_start;
        n_vic     = r_vic;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_idx[SLOT_W-1:0];
        fcmd.code = FC_NONE;
        fcmd.wr   = (r_op == OP_WRITE);
        fcmd.meta = r_meta;
        fcmd_idx  = r_vic;
        frd_idx   = r_cmp_idx;
        load_out  = 1'b0;
        o_hit     = 1'b0;
        o_slot    = r_vic;
        o_wb      = 1'b0;
        o_wbs     = '0;
        o_load    = 1'b0;
        o_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    case (s_axis_tuser[1:0])
                        OP_READ, OP_WRITE: n_state = S_SRCH;
                        OP_FLUSH:          n_state = S_FRD;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH: begin
                // tag of r_cmp_idx arrives while the next slot is read
                if (r_cmp_vld && fl.valid && (ram_rdata == r_sector)) begin
                    n_vic   = r_cmp_idx;
                    n_state = S_HIT;
                end else if (r_cmp_vld && (IW'(r_cmp_idx) == last_idx)) begin
                    n_hand  = hand_adv;
                    n_start = hand_adv;
                    n_state = S_SCAN;
                end else begin
                    ram_re    = issue;
                    n_cmp_vld = issue;
                    n_cmp_idx = r_idx[SLOT_W-1:0];
                    if (issue) begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_HIT: begin
                if (out_free) begin
                    fcmd.code = FC_HIT;
                    load_out  = 1'b1;
                    o_hit     = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SCAN: begin
                frd_idx  = r_hand;
                fcmd_idx = r_hand;
                if (fl.accessed || fl.meta_chance) begin
                    fcmd.code = fl.accessed ? FC_CLR_ACC : FC_CLR_META;
                    n_hand    = hand_adv;
                    if (hand_adv == r_start) begin
                        // full turn: fall back to the start slot
                        n_vic   = hand_adv;
                        n_state = S_VRD;
                    end
                end else begin
                    n_vic   = r_hand;
                    n_state = S_VRD;
                end
            end
            S_VRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_vic;
                n_state   = S_VOUT;
            end
            S_VOUT: begin
                frd_idx = r_vic;
                if (out_free) begin
                    o_wb      = fl.valid && fl.dirty;
                    o_wbs     = o_wb ? ram_rdata : '0;
                    o_load    = 1'b1;
                    load_out  = 1'b1;
                    ram_we    = 1'b1;
                    fcmd.code = FC_LOAD;
                    n_state   = S_IDLE;
                end
            end
            S_FRD: begin
                ram_re  = 1'b1;
                n_state = S_FOUT;
            end
            S_FOUT: begin
                frd_idx  = r_idx[SLOT_W-1:0];
                fcmd_idx = r_idx[SLOT_W-1:0];
                o_slot   = r_idx[SLOT_W-1:0];
                o_last   = (r_idx == last_idx);
                if (out_free) begin
                    o_wb      = fl.valid && fl.dirty;
                    o_wbs     = o_wb ? ram_rdata : '0;
                    load_out  = 1'b1;
                    fcmd.code = FC_CLR_DIRTY;
                    if (o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hand      <= SLOT_W'(CACHE_SLOTS - 1);
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hand    <= n_hand;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_start   <= n_start;
        r_vic     <= n_vic;
        if (accept) begin
            r_op     <= s_axis_tuser[1:0];
            r_meta   <= s_axis_tuser[2];
            r_sector <= s_axis_tdata[SECTOR_BITS-1:0];
        end
        if (load_out) begin
            r_out_data <= {o_load, o_wbs, o_wb, o_slot, o_hit};
            r_out_last <= o_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

endmodule

// File: design/sccr_chk.sv
module sccr_chk
    import sccr_pkg::*;
#(
    parameter int CACHE_SLOTS = 64,
    parameter int SECTOR_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [2:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [((SECTOR_BITS+$clog2(CACHE_SLOTS)+3+7)/8)*8-1:0] m_axis_tdata,
    input  logic                   m_axis_tlast
);

    localparam int SLOT_W   = $clog2(CACHE_SLOTS);
    localparam int WB_POS   = SLOT_W + 1;
    localparam int WBS_LO   = SLOT_W + 2;
    localparam int LOAD_POS = SLOT_W + SECTOR_BITS + 2;

    logic hit_bit;
    logic wb_bit;
    logic load_bit;

    assign hit_bit  = m_axis_tdata[0];
    assign wb_bit   = m_axis_tdata[WB_POS];
    assign load_bit = m_axis_tdata[LOAD_POS];

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // the engine works on one request at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != OP_NONE) |=> !s_axis_tready)
        else $error("request taken while busy");

    // a hit needs no load and no write-back and closes its request
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && hit_bit |-> !wb_bit && !load_bit && m_axis_tlast)
        else $error("hit result carries load or write-back");

    // write-back sector is zero unless a write-back is reported
    a_wbs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !wb_bit |-> (m_axis_tdata[WBS_LO +: SECTOR_BITS] == '0))
        else $error("write-back sector set without write-back");

endmodule

bind sector_cache_clock_replacement sccr_chk #(
    .CACHE_SLOTS (CACHE_SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
) u_sccr_chk (.*);

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sccr_pkg::*;

    localparam int SLOTS = 64;

    typedef struct {
        bit        hit;
        bit [5:0]  slot;
        bit        writeback;
        bit [31:0] writeback_sector;
        bit        load_needed;
        bit        last;
    } t_cache_result;

    // Tag store and clock hand mirror; predicts results per accepted request item
    class clock_cache_scoreboard;
        bit            valid[SLOTS];
        bit [31:0]     tag[SLOTS];
        bit            dirty[SLOTS];
        bit            accessed[SLOTS];
        bit            meta_chance[SLOTS];
        bit            holds_meta[SLOTS];
        int            hand;
        bit [6:0]      active_reg;
        t_cache_result expected_results[$];
        int            errors;

        function new();
            hand       = SLOTS - 1;
            active_reg = 7'd64;
            errors     = 0;
        endfunction

        function int live_slots();
            if (active_reg == 0) return 1;
            if (active_reg > SLOTS) return SLOTS;
            return int'(active_reg);
        endfunction

        function int step_hand(int n);
            hand = (hand + 1 >= n) ? 0 : hand + 1;
            return hand;
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] sector, logic meta);
            int            n;
            int            start;
            int            victim;
            t_cache_result r;
            n = live_slots();
            if (op == OP_FLUSH) begin
                for (int i = 0; i < n; i++) begin
                    r.hit              = 1'b0;
                    r.slot             = 6'(i);
                    r.writeback        = valid[i] && dirty[i];
                    r.writeback_sector = r.writeback ? tag[i] : 32'd0;
                    r.load_needed      = 1'b0;
                    r.last             = (i == n - 1);
                    expected_results.push_back(r);
                    dirty[i] = 1'b0;
                end
                return;
            end
            if (op == OP_NONE) return;

            for (int i = 0; i < n; i++) begin
                if (valid[i] && tag[i] == sector) begin
                    accessed[i] = 1'b1;
                    if (op == OP_WRITE) dirty[i] = 1'b1;
                    if (holds_meta[i]) meta_chance[i] = 1'b1;
                    r = '{1'b1, 6'(i), 1'b0, 32'd0, 1'b0, 1'b1};
                    expected_results.push_back(r);
                    return;
                end
            end

            // second chance scan; a full turn falls back on the start slot
            start  = step_hand(n);
            victim = start;
            forever begin
                if (accessed[victim]) accessed[victim] = 1'b0;
                else if (meta_chance[victim]) meta_chance[victim] = 1'b0;
                else break;
                victim = step_hand(n);
                if (victim == start) break;
            end

            r.hit              = 1'b0;
            r.slot             = 6'(victim);
            r.writeback        = valid[victim] && dirty[victim];
            r.writeback_sector = r.writeback ? tag[victim] : 32'd0;
            r.load_needed      = 1'b1;
            r.last             = 1'b1;
            expected_results.push_back(r);

            valid[victim]       = 1'b1;
            tag[victim]         = sector;
            holds_meta[victim]  = meta;
            accessed[victim]    = 1'b1;
            dirty[victim]       = (op == OP_WRITE);
            meta_chance[victim] = meta;
        endfunction

        function void check_result(logic [47:0] data, logic last);
            t_cache_result e;
            if (expected_results.size() == 0) begin
                $error("result item with none expected: slot %0d", data[6:1]);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (data[0] !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, data[0]);
                errors++;
            end
            if (data[6:1] !== e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, data[6:1]);
                errors++;
            end
            if (data[7] !== e.writeback) begin
                $error("writeback: expected %0d, got %0d", e.writeback, data[7]);
                errors++;
            end
            if (data[39:8] !== e.writeback_sector) begin
                $error("writeback_sector: expected %h, got %h", e.writeback_sector,
                       data[39:8]);
                errors++;
            end
            if (data[40] !== e.load_needed) begin
                $error("load_needed: expected %0d, got %0d", e.load_needed, data[40]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // sector
    logic [2:0]  s_axis_tuser;   // op [1:0], is_metadata [2]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // hit [0], slot [6:1], writeback [7], writeback_sector [39:8], load_needed [40]
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    clock_cache_scoreboard sb = new();
    logic [31:0] sector_pool[48];
    int          requests_sent = 0;
    int          results_seen  = 0;

    sector_cache_clock_replacement u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("sector_cache_clock_replacement verification failed");
        $finish;
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] sector,
                                input logic meta);
        int gap;
        // no gaps on the sender for a stretch of items
        if (!(requests_sent >= 120 && requests_sent < 200) && $urandom_range(99) < 14) begin
            gap = $urandom_range(4, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sector;
        s_axis_tuser  <= {meta, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, sector, meta);
        requests_sent++;
    endtask

    // drain all results, then allow for a request still running that gives none
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_active_slots(input logic [6:0] value);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_ACTIVE_SLOTS * 4);
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.active_reg = value;
    endtask

    task automatic random_requests(input int count, input int pool_size);
        int          issued;
        int          pick;
        logic [1:0]  op;
        logic [31:0] sector;
        issued = 0;
        while (issued < count) begin
            pick = $urandom_range(99);
            if (pick < 5) op = OP_FLUSH;
            else if (pick < 8) op = OP_NONE;
            else if (pick < 50) op = OP_WRITE;
            else op = OP_READ;
            // mostly a small working set so hits and second chances occur
            if ($urandom_range(99) < 80) sector = sector_pool[$urandom_range(pool_size - 1)];
            else sector = $urandom();
            send_request(op, sector, $urandom_range(99) < 30);
            if (op != OP_NONE) issued++;
        end
    endtask

    // result side: random stalls, one long hold-off, one stretch always ready
    initial begin
        int hold_left;
        int stall;
        hold_left = 0;
        stall     = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                results_seen++;
                if (results_seen == 150) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (!(results_seen >= 250 && results_seen < 450)
                         && $urandom_range(99) < 14) begin
                stall = $urandom_range(3, 0);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int phase_active[10];
        int live;
        int pool_size;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        phase_active = '{1, 0, 127, 3, 2, 5, 17, 64, 8, 0};
        phase_active[9] = $urandom_range(64, 1);
        foreach (sector_pool[i]) sector_pool[i] = $urandom();
        sector_pool[0] = 32'h0000_0000;
        sector_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty cache, hits on read and write, metadata load, no-op, flush
        send_request(OP_READ,  32'h0000_0000, 1'b0);
        send_request(OP_WRITE, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_READ,  32'hFFFF_FFFF, 1'b0);
        send_request(OP_WRITE, 32'h0000_0000, 1'b0);
        send_request(OP_READ,  32'hA5A5_5A5A, 1'b1);
        send_request(OP_NONE,  32'h1234_5678, 1'b1);
        send_request(OP_FLUSH, 32'h0000_0000, 1'b0);
        send_request(OP_WRITE, 32'h8000_0000, 1'b0);

        // one slot: hand past the count wraps, dirty victims write back
        set_active_slots(7'd1);
        send_request(OP_WRITE, 32'h0000_1234, 1'b0);
        send_request(OP_WRITE, 32'h0000_5678, 1'b1);
        send_request(OP_READ,  32'h0000_5678, 1'b0);

        // two slots: metadata survives an extra pass of the hand
        set_active_slots(7'd2);
        send_request(OP_WRITE, 32'h0000_00AA, 1'b1);
        send_request(OP_WRITE, 32'h0000_00BB, 1'b0);
        send_request(OP_READ,  32'h0000_00CC, 1'b0);
        send_request(OP_READ,  32'h0000_00AA, 1'b0);
        send_request(OP_READ,  32'h0000_00DD, 1'b0);
        send_request(OP_FLUSH, 32'hFFFF_FFFF, 1'b1);

        foreach (phase_active[p]) begin
            set_active_slots(7'(phase_active[p]));
            live = (phase_active[p] == 0) ? 1 : (phase_active[p] > SLOTS) ? SLOTS
                                               : phase_active[p];
            pool_size = live + live / 2 + 2;
            if (pool_size > 48) pool_size = 48;
            random_requests(32, pool_size);
        end

        wait_quiet();
        if (sb.errors == 0) begin
            $display("sector_cache_clock_replacement verification clean");
        end else begin
            $display("sector_cache_clock_replacement verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/sccr_pkg.sv
design/sccr_ram.sv
design/sccr_flags.sv
design/sector_cache_clock_replacement.sv
design/sccr_chk.sv
tb/testbench.sv
